// ===== rtl/core/lbf_pkg.sv =====
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared constants for the breathing LED fader: default sizes, command codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
package lbf_pkg;

    localparam int CURVE_COUNT_DEF  = 6;
    localparam int CURVE_LENGTH_DEF = 256;

    localparam int CMD_W  = 2;
    localparam int TBL_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;

    // Command codes carried by an input item.
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_FACTOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FACTOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_ENABLE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ENABLE     = 3'd7;

endpackage

// ===== rtl/core/led_breathing_fader_core.sv =====
// ----------------------------------------------------------------------------
// led_breathing_fader_core
// Breathing LED intensity engine with curve tables and a bit-serial shaper.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    command, table_number, entry_address,
//                                   entry_value, new_position, new_falling
//  result    out_valid / out_ready  intensity, position, falling, at_lower,
//                                   at_upper, direction_changed
//  config    cfg_write              cfg_index, cfg_data
//
// A tick item reads the curve memory as it is accepted, then loads the
// shaper and runs three shift-add multiplies on one 9-bit adder. Load, set
// position and unused commands skip the shaper. One item is worked on at a
// time; the next item is accepted as soon as the previous result sits in the
// output register. A stalled result holds the shaper in its final state.
// Reset clears control state; the curve memory holds no reset value.
// ----------------------------------------------------------------------------
module led_breathing_fader_core #(
    parameter int CURVE_COUNT  = lbf_pkg::CURVE_COUNT_DEF,
    parameter int CURVE_LENGTH = lbf_pkg::CURVE_LENGTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbf_pkg::BYTE_W-1:0]    cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lbf_pkg::CMD_W-1:0]     command,
    input  logic [lbf_pkg::TBL_W-1:0]     table_number,
    input  logic [lbf_pkg::BYTE_W-1:0]    entry_address,
    input  logic [lbf_pkg::BYTE_W-1:0]    entry_value,
    input  logic [lbf_pkg::BYTE_W-1:0]    new_position,
    input  logic                          new_falling,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lbf_pkg::BYTE_W-1:0]    intensity,
    output logic [lbf_pkg::BYTE_W-1:0]    position,
    output logic                          falling,
    output logic                          at_lower,
    output logic                          at_upper,
    output logic                          direction_changed
);

    import lbf_pkg::*;

    localparam int DEPTH = CURVE_COUNT * CURVE_LENGTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] PH_DIM   = 2'd0;
    localparam logic [1:0] PH_FLOOR = 2'd1;
    localparam logic [1:0] PH_COLOR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [TBL_W-1:0]  curve_select_reg;
    logic [BYTE_W-1:0] dim_factor_reg;
    logic [BYTE_W-1:0] color_factor_reg;
    logic [BYTE_W-1:0] floor_reg;
    logic [BYTE_W-1:0] lower_bound_reg;
    logic [BYTE_W-1:0] upper_bound_reg;
    logic              fade_enable_reg;
    logic              step_enable_reg;

    // Engine state.
    state_t            state_reg;
    logic [BYTE_W-1:0] position_reg;
    logic              falling_reg;
    logic              at_lower_reg;
    logic              at_upper_reg;
    logic              changed_reg;
    logic [BYTE_W-1:0] intensity_reg;

    // Bit-serial multiplier.
    logic [BYTE_W-1:0] mcand_reg;
    logic [BYTE_W-1:0] mplier_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [2:0]        cnt_reg;
    logic [1:0]        phase_reg;

    // Output register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_intensity_reg;
    logic [BYTE_W-1:0] out_position_reg;
    logic              out_falling_reg;
    logic              out_at_lower_reg;
    logic              out_at_upper_reg;
    logic              out_changed_reg;

    // Curve memory.
    logic [BYTE_W-1:0] curve_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_oob_reg;

    logic              accept;
    logic              is_tick;
    logic              step_go;
    logic [BYTE_W-1:0] pos_step;
    logic              hit;
    logic [BYTE_W-1:0] pos_next;
    logic              rd_oob_next;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] prod;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_tick  = (command == CMD_TICK);
    assign step_go  = is_tick && fade_enable_reg && step_enable_reg;

    assign pos_step = falling_reg ? (position_reg - 8'd1) : (position_reg + 8'd1);
    assign hit      = falling_reg ? (pos_step == lower_bound_reg)
                                  : (pos_step == upper_bound_reg);
    assign pos_next = step_go ? pos_step : position_reg;

    assign rd_oob_next = (32'(curve_select_reg) >= CURVE_COUNT)
                      || (32'(pos_next) >= CURVE_LENGTH);
    assign rd_addr = AW'(32'(curve_select_reg) * CURVE_LENGTH + 32'(pos_next));
    assign wr_addr = AW'(32'(table_number) * CURVE_LENGTH + 32'(entry_address));
    assign wr_en   = accept && (command == CMD_LOAD)
                  && (32'(table_number) < CURVE_COUNT)
                  && (32'(entry_address) < CURVE_LENGTH);

    // One shift-add step: the high byte of the product builds up from the
    // multiplier's low bit first, one bit per cycle.
    assign sum  = {1'b0, acc_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : 9'd0);
    assign prod = sum[BYTE_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_select_reg <= '0;
            dim_factor_reg   <= 8'd255;
            color_factor_reg <= 8'd255;
            floor_reg        <= '0;
            lower_bound_reg  <= '0;
            upper_bound_reg  <= 8'd255;
            fade_enable_reg  <= 1'b1;
            step_enable_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CURVE_SELECT:    curve_select_reg <= cfg_data[TBL_W-1:0];
                CFG_DIM_FACTOR:      dim_factor_reg   <= cfg_data;
                CFG_COLOR_FACTOR:    color_factor_reg <= cfg_data;
                CFG_INTENSITY_FLOOR: floor_reg        <= cfg_data;
                CFG_LOWER_BOUND:     lower_bound_reg  <= cfg_data;
                CFG_UPPER_BOUND:     upper_bound_reg  <= cfg_data;
                CFG_FADE_ENABLE:     fade_enable_reg  <= cfg_data[0];
                CFG_STEP_ENABLE:     step_enable_reg  <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_addr] <= entry_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_tick)
        begin
            rd_data_reg <= curve_mem[rd_addr];
            rd_oob_reg  <= rd_oob_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            position_reg      <= '0;
            falling_reg       <= 1'b0;
            at_lower_reg      <= 1'b0;
            at_upper_reg      <= 1'b0;
            changed_reg       <= 1'b0;
            intensity_reg     <= '0;
            mcand_reg         <= '0;
            mplier_reg        <= '0;
            acc_reg           <= '0;
            cnt_reg           <= '0;
            phase_reg         <= PH_DIM;
            out_valid_reg     <= 1'b0;
            out_intensity_reg <= '0;
            out_position_reg  <= '0;
            out_falling_reg   <= 1'b0;
            out_at_lower_reg  <= 1'b0;
            out_at_upper_reg  <= 1'b0;
            out_changed_reg   <= 1'b0;
        end
        else
        begin
            // A taken result is replaced directly when the next one is ready.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (is_tick)
                        begin
                            if (step_go)
                            begin
                                position_reg <= pos_step;
                                changed_reg  <= hit;
                                if (hit)
                                begin
                                    falling_reg  <= !falling_reg;
                                    at_lower_reg <= falling_reg;
                                    at_upper_reg <= !falling_reg;
                                end
                            end
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            if (command == CMD_SET_POS)
                            begin
                                position_reg <= new_position;
                                falling_reg  <= new_falling;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_LOAD:
                begin
                    // 255 - c is the bitwise inverse; an out-of-range read is zero.
                    mcand_reg  <= rd_oob_reg ? 8'hFF : ~rd_data_reg;
                    mplier_reg <= dim_factor_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                    phase_reg  <= PH_DIM;
                    state_reg  <= S_MUL;
                end

                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        acc_reg <= '0;
                        unique case (phase_reg)
                            PH_DIM:
                            begin
                                mcand_reg  <= ~prod;
                                mplier_reg <= ~floor_reg;
                                phase_reg  <= PH_FLOOR;
                            end
                            PH_FLOOR:
                            begin
                                mcand_reg  <= color_factor_reg;
                                mplier_reg <= prod + floor_reg;
                                phase_reg  <= PH_COLOR;
                            end
                            default:
                            begin
                                intensity_reg <= prod;
                                state_reg     <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg    <= prod;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_intensity_reg <= intensity_reg;
                        out_position_reg  <= position_reg;
                        out_falling_reg   <= falling_reg;
                        out_at_lower_reg  <= at_lower_reg;
                        out_at_upper_reg  <= at_upper_reg;
                        out_changed_reg   <= changed_reg;
                        state_reg         <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign intensity         = out_intensity_reg;
    assign position          = out_position_reg;
    assign falling           = out_falling_reg;
    assign at_lower          = out_at_lower_reg;
    assign at_upper          = out_at_upper_reg;
    assign direction_changed = out_changed_reg;

endmodule

// ===== rtl/core/lbf_checker.sv =====
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level checks for the breathing LED fader, bound to the fader core.
// ----------------------------------------------------------------------------
module lbf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lbf_pkg::BYTE_W-1:0]    intensity,
    input logic [lbf_pkg::BYTE_W-1:0]    position,
    input logic                          falling,
    input logic                          at_lower,
    input logic                          at_upper,
    input logic                          direction_changed
);

    import lbf_pkg::*;

    // Items accepted whose result has not yet been taken.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready)
        begin
            pending_next = pending_next + 2'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(intensity)
            && $stable(position) && $stable(falling) && $stable(direction_changed))
        else $error("result changed while stalled");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items in flight");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no item in flight");

    a_bounds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(at_lower && at_upper))
        else $error("both bound flags set");

endmodule

bind led_breathing_fader_core lbf_checker u_lbf_checker (.*);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for led_breathing_fader_core. It holds a shadow copy of
// the curve tables, position walk and intensity shaping. Every accepted item
// is applied to the shadow, and the expected output is queued. Each result
// the block returns is compared field by field against the oldest entry.
// Stimulus has a short directed part and then random phases. The phases use
// different register settings and different idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import lbf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [TBL_W-1:0]  table_number;
        logic [BYTE_W-1:0] entry_address;
        logic [BYTE_W-1:0] entry_value;
        logic [BYTE_W-1:0] new_position;
        logic              new_falling;
    } fader_cmd_t;

    typedef struct {
        logic [BYTE_W-1:0] intensity;
        logic [BYTE_W-1:0] position;
        logic              falling;
        logic              at_lower;
        logic              at_upper;
        logic              direction_changed;
    } fader_out_t;

    class fader_shadow;
        logic [TBL_W-1:0]  sel;
        logic [BYTE_W-1:0] dim;
        logic [BYTE_W-1:0] color;
        logic [BYTE_W-1:0] floor_lvl;
        logic [BYTE_W-1:0] lower;
        logic [BYTE_W-1:0] upper;
        logic              fade_en;
        logic              step_en;

        logic [BYTE_W-1:0] curve_mem [CURVE_COUNT_DEF][CURVE_LENGTH_DEF];
        bit                written   [CURVE_COUNT_DEF][CURVE_LENGTH_DEF];
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] level;
        logic              falling;
        logic              at_lo;
        logic              at_hi;
        logic              changed;

        fader_out_t        due_outputs[$];
        int                faults;

        function new();
            sel = '0;
            dim = 8'd255;
            color = 8'd255;
            floor_lvl = '0;
            lower = '0;
            upper = 8'd255;
            fade_en = 1'b1;
            step_en = 1'b1;
            pos = '0;
            level = '0;
            falling = 1'b0;
            at_lo = 1'b0;
            at_hi = 1'b0;
            changed = 1'b0;
            faults = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                CFG_CURVE_SELECT:    sel = data[TBL_W-1:0];
                CFG_DIM_FACTOR:      dim = data;
                CFG_COLOR_FACTOR:    color = data;
                CFG_INTENSITY_FLOOR: floor_lvl = data;
                CFG_LOWER_BOUND:     lower = data;
                CFG_UPPER_BOUND:     upper = data;
                CFG_FADE_ENABLE:     fade_en = data[0];
                CFG_STEP_ENABLE:     step_en = data[0];
                default: ;
            endcase
        endfunction

        // Curve address that the next tick reads, or -1 when the selected
        // table does not exist and the entry reads as zero.
        function int tick_addr();
            logic [BYTE_W-1:0] next_pos;
            next_pos = pos;
            if (fade_en && step_en)
                next_pos = falling ? pos - 8'd1 : pos + 8'd1;
            if (sel >= CURVE_COUNT_DEF)
                return -1;
            return int'(next_pos);
        endfunction

        function void walk_position();
            changed = 1'b0;
            if (falling) begin
                pos = pos - 8'd1;
                if (pos == lower) begin
                    at_lo = 1'b1;
                    at_hi = 1'b0;
                    falling = 1'b0;
                    changed = 1'b1;
                end
            end
            else begin
                pos = pos + 8'd1;
                if (pos == upper) begin
                    at_lo = 1'b0;
                    at_hi = 1'b1;
                    falling = 1'b1;
                    changed = 1'b1;
                end
            end
        endfunction

        function logic [BYTE_W-1:0] shade_level();
            int unsigned curve_val;
            int unsigned pulled;
            int unsigned lifted;
            curve_val = 0;
            if (sel < CURVE_COUNT_DEF)
                curve_val = curve_mem[sel][pos];
            pulled = ((255 - curve_val) * int'(dim)) >> 8;
            lifted = (((255 - pulled) * (255 - int'(floor_lvl))) >> 8) + floor_lvl;
            return BYTE_W'((int'(color) * lifted) >> 8);
        endfunction

        function void take_command(fader_cmd_t c);
            case (c.command)
                CMD_TICK: begin
                    if (fade_en && step_en)
                        walk_position();
                    level = shade_level();
                end
                CMD_LOAD: begin
                    if (c.table_number < CURVE_COUNT_DEF) begin
                        curve_mem[c.table_number][c.entry_address] = c.entry_value;
                        written[c.table_number][c.entry_address] = 1'b1;
                    end
                end
                CMD_SET_POS: begin
                    pos = c.new_position;
                    falling = c.new_falling;
                end
                default: ;
            endcase
            due_outputs.push_back(fader_out_t'{level, pos, falling, at_lo, at_hi, changed});
        endfunction

        function void check_output(fader_out_t got);
            fader_out_t want;
            if (due_outputs.size() == 0) begin
                $error("result with nothing pending: intensity %0d, position %0d",
                       got.intensity, got.position);
                faults++;
                return;
            end
            want = due_outputs.pop_front();
            if (got.intensity !== want.intensity) begin
                $error("intensity: expected %0d, got %0d", want.intensity, got.intensity);
                faults++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                faults++;
            end
            if (got.falling !== want.falling) begin
                $error("falling: expected %0b, got %0b", want.falling, got.falling);
                faults++;
            end
            if (got.at_lower !== want.at_lower) begin
                $error("at_lower: expected %0b, got %0b", want.at_lower, got.at_lower);
                faults++;
            end
            if (got.at_upper !== want.at_upper) begin
                $error("at_upper: expected %0b, got %0b", want.at_upper, got.at_upper);
                faults++;
            end
            if (got.direction_changed !== want.direction_changed) begin
                $error("direction_changed: expected %0b, got %0b",
                       want.direction_changed, got.direction_changed);
                faults++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [TBL_W-1:0]     table_number;
    logic [BYTE_W-1:0]    entry_address;
    logic [BYTE_W-1:0]    entry_value;
    logic [BYTE_W-1:0]    new_position;
    logic                 new_falling;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    intensity;
    logic [BYTE_W-1:0]    position;
    logic                 falling;
    logic                 at_lower;
    logic                 at_upper;
    logic                 direction_changed;

    fader_shadow shadow;
    int          send_idle;
    int          recv_stall;
    int          hold_requests;
    int          cycle_count;

    led_breathing_fader_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .table_number      (table_number),
        .entry_address     (entry_address),
        .entry_value       (entry_value),
        .new_position      (new_position),
        .new_falling       (new_falling),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .intensity         (intensity),
        .position          (position),
        .falling           (falling),
        .at_lower          (at_lower),
        .at_upper          (at_upper),
        .direction_changed (direction_changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic fader_cmd_t mk(logic [CMD_W-1:0] cmd, logic [TBL_W-1:0] tbl,
                                      logic [BYTE_W-1:0] adr, logic [BYTE_W-1:0] val,
                                      logic [BYTE_W-1:0] npos, logic nfall);
        fader_cmd_t c;
        c.command = cmd;
        c.table_number = tbl;
        c.entry_address = adr;
        c.entry_value = val;
        c.new_position = npos;
        c.new_falling = nfall;
        return c;
    endfunction

    // Entered and left at a falling edge. Valid stays high on return so that
    // a following item can go out back to back; callers lower it when done.
    task automatic send_item(fader_cmd_t c);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= c.command;
        table_number <= c.table_number;
        entry_address <= c.entry_address;
        entry_value <= c.entry_value;
        new_position <= c.new_position;
        new_falling <= c.new_falling;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.take_command(c);
        @(negedge clk);
    endtask

    // A tick never reads a curve entry that was never written: a load of that
    // entry goes out first.
    task automatic send_tick();
        int adr;
        adr = shadow.tick_addr();
        if (adr >= 0 && !shadow.written[shadow.sel][adr])
            send_item(mk(CMD_LOAD, shadow.sel, BYTE_W'(adr), BYTE_W'($urandom),
                         BYTE_W'($urandom), 1'($urandom)));
        send_item(mk(CMD_TICK, TBL_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), 1'($urandom)));
    endtask

    task automatic send_random_item();
        int pick;
        logic [BYTE_W-1:0] npos;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_tick();
        end
        else if (pick < 75) begin
            send_item(mk(CMD_LOAD, TBL_W'($urandom_range(CURVE_COUNT_DEF - 1)),
                         BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         1'($urandom)));
        end
        else if (pick < 80) begin
            // Tables past the last one do not exist; the load is dropped.
            send_item(mk(CMD_LOAD, TBL_W'($urandom_range(7, CURVE_COUNT_DEF)),
                         BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         1'($urandom)));
        end
        else if (pick < 95) begin
            // Mostly land between the bounds so that turns come soon.
            npos = BYTE_W'($urandom);
            if ($urandom_range(3) != 0)
                npos = BYTE_W'($urandom_range(shadow.upper, shadow.lower));
            send_item(mk(CMD_SET_POS, TBL_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), npos, 1'($urandom)));
        end
        else begin
            send_item(mk(CMD_UNUSED, TBL_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), BYTE_W'($urandom), 1'($urandom)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (shadow.due_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        shadow.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [BYTE_W-1:0] sel, logic [BYTE_W-1:0] dim,
                                logic [BYTE_W-1:0] color, logic [BYTE_W-1:0] flr,
                                logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi,
                                logic [BYTE_W-1:0] fade, logic [BYTE_W-1:0] step);
        drain();
        write_reg(CFG_CURVE_SELECT, sel);
        write_reg(CFG_DIM_FACTOR, dim);
        write_reg(CFG_COLOR_FACTOR, color);
        write_reg(CFG_INTENSITY_FLOOR, flr);
        write_reg(CFG_LOWER_BOUND, lo);
        write_reg(CFG_UPPER_BOUND, hi);
        write_reg(CFG_FADE_ENABLE, fade);
        write_reg(CFG_STEP_ENABLE, step);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit pause_midway, bit hold_midway);
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && pause_midway)
                drain();
            if (n == PHASE_ITEMS / 4 && hold_midway)
                hold_requests++;
            send_random_item();
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        int seen_requests;
        hold_left = 0;
        seen_requests = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != seen_requests) begin
                seen_requests = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_output(fader_out_t'{intensity, position, falling, at_lower,
                                             at_upper, direction_changed});
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** led_breathing_fader_core: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_TICK;
        table_number = '0;
        entry_address = '0;
        entry_value = '0;
        new_position = '0;
        new_falling = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_requests = 0;
        shadow = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset settings: value extremes, turns at both
        // bounds, wrap in both directions, dropped loads, unused command.
        send_item(mk(CMD_LOAD, 3'd0, 8'd1, 8'd0, 8'd0, 1'b0));
        send_tick();
        send_item(mk(CMD_LOAD, 3'd0, 8'd2, 8'd255, 8'd0, 1'b0));
        send_tick();
        send_item(mk(CMD_LOAD, 3'd7, 8'd3, 8'd255, 8'd0, 1'b0));
        send_item(mk(CMD_LOAD, 3'd6, 8'd3, 8'd0, 8'd0, 1'b0));
        send_item(mk(CMD_SET_POS, 3'd0, 8'd0, 8'd0, 8'd254, 1'b0));
        send_item(mk(CMD_LOAD, 3'd0, 8'd255, 8'd200, 8'd0, 1'b0));
        send_tick();
        send_item(mk(CMD_LOAD, 3'd0, 8'd254, 8'd17, 8'd0, 1'b0));
        send_tick();
        send_item(mk(CMD_SET_POS, 3'd0, 8'd0, 8'd0, 8'd1, 1'b1));
        send_item(mk(CMD_LOAD, 3'd0, 8'd0, 8'd99, 8'd0, 1'b0));
        send_tick();
        send_item(mk(CMD_SET_POS, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        send_tick();
        send_item(mk(CMD_SET_POS, 3'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        send_tick();
        send_item(mk(CMD_UNUSED, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1));
        send_item(mk(CMD_LOAD, 3'd5, 8'd255, 8'd255, 8'd255, 1'b1));
        send_item(mk(CMD_SET_POS, 3'd5, 8'd255, 8'd255, 8'd255, 1'b1));

        // Frozen ticks keep position and flags, then a missing table reads zero.
        program_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1);
        send_tick();
        send_tick();
        program_regs(8'd6, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd1);
        send_tick();

        program_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd1);
        run_phase(0, 0, 1'b0, 1'b0);
        program_regs(8'd1, 8'd128, 8'd200, 8'd30, 8'd40, 8'd60, 8'd1, 8'd1);
        run_phase(50, 0, 1'b0, 1'b0);
        program_regs(8'd5, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd1);
        run_phase(0, 50, 1'b1, 1'b0);
        program_regs(8'd2, 8'd77, 8'd255, 8'd0, 8'd10, 8'd20, 8'd0, 8'd1);
        run_phase(34, 34, 1'b0, 1'b0);
        program_regs(8'd3, 8'd255, 8'd128, 8'd200, 8'd0, 8'd255, 8'd1, 8'd0);
        run_phase(0, 0, 1'b0, 1'b0);
        program_regs(8'd6, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     8'd100, 8'd120, 8'd1, 8'd1);
        run_phase(50, 0, 1'b0, 1'b0);
        program_regs(8'hFF, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     8'd200, 8'd180, 8'hFF, 8'h81);
        run_phase(0, 50, 1'b0, 1'b1);
        program_regs(BYTE_W'($urandom_range(CURVE_COUNT_DEF - 1)), BYTE_W'($urandom),
                     BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom_range(127)),
                     BYTE_W'($urandom_range(255, 128)), 8'd1, 8'd1);
        run_phase(34, 34, 1'b1, 1'b1);

        drain();
        repeat (40) @(negedge clk);
        if (shadow.faults == 0 && shadow.due_outputs.size() == 0)
            $display("** led_breathing_fader_core: PASSED **");
        else
            $display("** led_breathing_fader_core: FAILED **");
        $finish;
    end

endmodule
